[design/acb_pkg.sv]
// Shared types and constants for the ack coalescing buffer.
package acb_pkg;

    localparam int CID_W   = 64;
    localparam int PORT_W  = 16;
    localparam int TOTAL_W = 6;
    localparam int ENTRY_W = CID_W + PORT_W;
    localparam int IN_DATA_W  = 88;
    localparam int OUT_DATA_W = 88;

    // Command carried in the input tuser.
    localparam logic CMD_ADD  = 1'b0;
    localparam logic CMD_TAKE = 1'b1;

    // Kind of a result item, carried in the output tuser.
    typedef enum logic [1:0] {
        KIND_FLUSH_HDR = 2'd0,
        KIND_FLUSH_ENT = 2'd1,
        KIND_TAKE_ENT  = 2'd2,
        KIND_NONE      = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_HDR,
        ST_READ,
        ST_ENTRY
    } t_state;

    // Controller to datapath.
    typedef struct packed {
        logic accept;     // input item taken this cycle
        logic load_hdr;   // load header or empty marker into output register
        logic rd_en;      // read the store at the job pointer
        logic load_entry; // load read data into output register, advance job
        logic rd_next;    // with rd_en: read the entry after the job pointer
    } t_dp_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic is_add;     // incoming item is an add
        logic add_room;   // incoming add fits into the store
        logic take_none;  // incoming take removes nothing
        logic left_zero;  // no entries left in the current job
        logic left_one;   // exactly one entry left in the current job
        logic out_free;   // output register can take a new item
    } t_dp_status;

endpackage

[design/acb_dpath.sv]
// Datapath: ack store, counters, job registers and the output register.
module acb_dpath
    import acb_pkg::*;
#(
    parameter int ACK_SLOTS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    input  logic                  i_s_tuser,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [OUT_DATA_W-1:0] o_m_tdata,
    output logic [1:0]            o_m_tuser,
    output logic                  o_m_tlast,
    input  t_dp_cmd               i_cmd,
    output t_dp_status            o_status
);

    localparam int CNT_W = $clog2(ACK_SLOTS + 1);
    localparam int IDX_W = (ACK_SLOTS > 1) ? $clog2(ACK_SLOTS) : 1;

    logic [ENTRY_W-1:0] r_mem [ACK_SLOTS];
    logic [ENTRY_W-1:0] r_rd_data;

    logic [CNT_W-1:0]   r_count, n_count;
    logic [CNT_W-1:0]   r_left, n_left;
    logic [CNT_W-1:0]   r_total, n_total;
    logic [IDX_W-1:0]   r_ptr, n_ptr;
    logic               r_flush, n_flush;
    logic [CID_W-1:0]   r_hdr_cid, n_hdr_cid;
    logic [PORT_W-1:0]  r_hdr_port, n_hdr_port;

    logic               r_out_valid;
    t_kind              r_out_kind;
    logic [CID_W-1:0]   r_out_cid;
    logic [PORT_W-1:0]  r_out_port;
    logic [TOTAL_W-1:0] r_out_total;
    logic               r_out_last;

    logic [CID_W-1:0]   w_cid;
    logic [PORT_W-1:0]  w_port;
    logic [TOTAL_W-1:0] w_want;
    logic [CNT_W-1:0]   w_take_n;
    logic               w_room;
    logic [IDX_W-1:0]   w_rd_addr;

    assign w_cid  = i_s_tdata[CID_W-1:0];
    assign w_port = i_s_tdata[ENTRY_W-1:CID_W];
    assign w_want = i_s_tdata[ENTRY_W+TOTAL_W-1:ENTRY_W];
    assign w_room = r_count < CNT_W'(ACK_SLOTS);
    assign w_take_n = (w_want < TOTAL_W'(r_count)) ? w_want[CNT_W-1:0] : r_count;

    assign o_status.is_add    = (i_s_tuser == CMD_ADD);
    assign o_status.add_room  = (i_s_tuser == CMD_ADD) && w_room;
    assign o_status.take_none = (i_s_tuser == CMD_TAKE) && (w_take_n == '0);
    assign o_status.left_zero = (r_left == '0);
    assign o_status.left_one  = (r_left == CNT_W'(1));
    assign o_status.out_free  = !r_out_valid || i_m_tready;

    always_comb begin
        n_count    = r_count;
        n_left     = r_left;
        n_total    = r_total;
        n_ptr      = r_ptr;
        n_flush    = r_flush;
        n_hdr_cid  = r_hdr_cid;
        n_hdr_port = r_hdr_port;
        if (i_cmd.accept) begin
            if (i_s_tuser == CMD_ADD) begin
                if (w_room) begin
                    n_count = r_count + CNT_W'(1);
                end else begin
                    n_flush    = 1'b1;
                    n_hdr_cid  = w_cid;
                    n_hdr_port = w_port;
                    n_total    = r_count;
                    n_left     = r_count;
                    n_ptr      = '0;
                    n_count    = '0;
                end
            end else begin
                n_flush    = 1'b0;
                n_hdr_cid  = '0;
                n_hdr_port = '0;
                n_total    = w_take_n;
                n_left     = w_take_n;
                n_ptr      = IDX_W'(r_count - w_take_n);
                n_count    = r_count - w_take_n;
            end
        end else if (i_cmd.load_entry) begin
            n_left = r_left - CNT_W'(1);
            n_ptr  = r_ptr + IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_left  <= '0;
        end else begin
            r_count <= n_count;
            r_left  <= n_left;
        end
    end

    always_ff @(posedge i_clk) begin
        r_total    <= n_total;
        r_ptr      <= n_ptr;
        r_flush    <= n_flush;
        r_hdr_cid  <= n_hdr_cid;
        r_hdr_port <= n_hdr_port;
    end

    // Single write port and single registered read port.
    assign w_rd_addr = i_cmd.rd_next ? r_ptr + IDX_W'(1) : r_ptr;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && o_status.add_room) begin
            r_mem[r_count[IDX_W-1:0]] <= {w_port, w_cid};
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_hdr || i_cmd.load_entry) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_hdr) begin
            r_out_kind  <= r_flush ? KIND_FLUSH_HDR : KIND_NONE;
            r_out_cid   <= r_hdr_cid;
            r_out_port  <= r_hdr_port;
            r_out_total <= TOTAL_W'(r_total);
            r_out_last  <= (r_left == '0);
        end else if (i_cmd.load_entry) begin
            r_out_kind  <= r_flush ? KIND_FLUSH_ENT : KIND_TAKE_ENT;
            r_out_cid   <= r_rd_data[CID_W-1:0];
            r_out_port  <= r_rd_data[ENTRY_W-1:CID_W];
            r_out_total <= TOTAL_W'(r_total);
            r_out_last  <= (r_left == CNT_W'(1));
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(OUT_DATA_W - ENTRY_W - TOTAL_W){1'b0}},
                         r_out_total, r_out_port, r_out_cid};
    assign o_m_tuser  = r_out_kind;
    assign o_m_tlast  = r_out_last;

endmodule

[design/acb_ctrl.sv]
// Controller state machine that sequences headers and entry reads.
module acb_ctrl
    import acb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.accept = 1'b1;
                    if (i_status.add_room) begin
                        n_state = ST_IDLE;
                    end else if (i_status.is_add || i_status.take_none) begin
                        n_state = ST_HDR;
                    end else begin
                        n_state = ST_READ;
                    end
                end
            end
            ST_HDR: begin
                if (i_status.out_free) begin
                    o_cmd.load_hdr = 1'b1;
                    n_state = i_status.left_zero ? ST_IDLE : ST_READ;
                end
            end
            ST_READ: begin
                o_cmd.rd_en = 1'b1;
                n_state = ST_ENTRY;
            end
            ST_ENTRY: begin
                if (i_status.out_free) begin
                    o_cmd.load_entry = 1'b1;
                    if (i_status.left_one) begin
                        n_state = ST_IDLE;
                    end else begin
                        o_cmd.rd_en   = 1'b1;
                        o_cmd.rd_next = 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

[design/ack_coalescing_buffer_core.sv]
// Top level of the ack coalescing buffer: controller, datapath and checks.
//
// This block gathers pending RPC acknowledgements for one peer in a store of
// ACK_SLOTS entries. An add item stores its ack and produces no result while
// there is room; an add that finds the store full produces a flush: a header
// item with the new RPC's id and port and the stored count, followed by every
// stored entry from oldest to newest, after which the store counts as empty
// and the new ack is dropped. A take item removes up to take_count of the
// newest entries and sends them oldest first, or sends a single empty marker
// when nothing is removed. The block takes one input item at a time. The
// store has one registered read port, and results leave through one output
// register at one item per cycle once streaming, while the output does not
// stall. The input is accepted again as soon as the last result of an item
// has been loaded into the output register, even while that result still
// waits to be taken.
module ack_coalescing_buffer_core
    import acb_pkg::*;
#(
    parameter int ACK_SLOTS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // client_id [63:0], server_port [79:64], take_count [85:80], zero pad
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    // command [0]
    input  logic                  i_s_tuser,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // ack_client_id [63:0], ack_server_port [79:64], ack_total [85:80], zero pad
    output logic [OUT_DATA_W-1:0] o_m_tdata,
    // kind [1:0]
    output logic [1:0]            o_m_tuser,
    // last result caused by an input item
    output logic                  o_m_tlast
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    acb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    acb_dpath #(
        .ACK_SLOTS (ACK_SLOTS)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast),
        .i_cmd      (w_cmd),
        .o_status   (w_status)
    );

    // The output register is only loaded when it is empty or being drained.
    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.load_hdr || w_cmd.load_entry) |-> w_status.out_free)
        else $error("output register overwritten while holding an item");

    // Any item that produces results closes the input for the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && !w_status.add_room) |=> !o_s_tready)
        else $error("input reopened before results were produced");

    // A flush only happens on a full store, so its header reports every slot.
    a_flush_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser == KIND_FLUSH_HDR)
            |-> (o_m_tdata[ENTRY_W+TOTAL_W-1:ENTRY_W] == TOTAL_W'(ACK_SLOTS)))
        else $error("flush header count differs from store size");

    // The empty marker is always a single, final, all-zero result.
    a_empty_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser == KIND_NONE)
            |-> (o_m_tlast && o_m_tdata == '0))
        else $error("malformed empty marker");

endmodule

[test/ack_coalescing_buffer_core_tb.sv]
// Self-checking testbench for the ack coalescing buffer core.
`timescale 1ns / 100ps

module ack_coalescing_buffer_core_tb
    import acb_pkg::*;
();

    localparam int ACK_SLOTS      = 8;
    localparam int ITEMS_PER_PHASE = 56;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 4000;

    // One result item as the block is expected to send it.
    typedef struct packed {
        t_kind              kind;
        logic [CID_W-1:0]   cid;
        logic [PORT_W-1:0]  port;
        logic [TOTAL_W-1:0] total;
        logic               last;
    } t_ack_result;

    // One row of the directed stimulus table.
    typedef struct {
        logic               cmd;
        logic [CID_W-1:0]   cid;
        logic [PORT_W-1:0]  port;
        logic [TOTAL_W-1:0] take;
        bit                 typed;
        t_ack_result        want;
    } t_stim_row;

    localparam t_ack_result EMPTY_MARKER = '{KIND_NONE, '0, '0, '0, 1'b1};

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  s_tuser = CMD_ADD;
    logic                  m_tready = 1'b0;
    logic                  o_s_tready;
    logic                  o_m_tvalid;
    logic [OUT_DATA_W-1:0] o_m_tdata;
    logic [1:0]            o_m_tuser;
    logic                  o_m_tlast;

    // Predictor state: the pending acks and how many there are.
    logic [CID_W-1:0]  pend_cid [ACK_SLOTS];
    logic [PORT_W-1:0] pend_port [ACK_SLOTS];
    int unsigned       pend_count = 0;

    t_ack_result predicted_acks [$];
    t_ack_result expected_acks [$];
    t_stim_row   stim_rows [$];

    int mismatch_count = 0;
    int results_checked = 0;
    int adds_sent = 0;
    int takes_sent = 0;
    int flushes_seen = 0;
    int quiet_cycles = 0;
    int idle_pct = 0;
    int stall_pct = 0;
    int hold_req = 0;
    int hold_seen = 0;
    int hold_left = 0;

    ack_coalescing_buffer_core #(
        .ACK_SLOTS(ACK_SLOTS)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Works out the results of one accepted input item into predicted_acks and
    // advances the pending-ack state.
    function automatic void predict_ack_item(logic cmd, logic [CID_W-1:0] cid,
                                             logic [PORT_W-1:0] port,
                                             logic [TOTAL_W-1:0] take);
        int unsigned n;
        int unsigned first;
        predicted_acks.delete();
        if (cmd == CMD_ADD) begin
            if (pend_count < ACK_SLOTS) begin
                pend_cid[pend_count] = cid;
                pend_port[pend_count] = port;
                pend_count++;
            end else begin
                // A full store turns the add into a flush; the new ack is dropped.
                n = pend_count;
                predicted_acks.push_back('{KIND_FLUSH_HDR, cid, port, TOTAL_W'(n), n == 0});
                for (int i = 0; i < n; i++) begin
                    predicted_acks.push_back('{KIND_FLUSH_ENT, pend_cid[i], pend_port[i],
                                               TOTAL_W'(n), i + 1 == n});
                end
                pend_count = 0;
                flushes_seen++;
            end
        end else begin
            n = (take < pend_count) ? take : pend_count;
            if (n == 0) begin
                predicted_acks.push_back(EMPTY_MARKER);
            end else begin
                // The newest n entries leave, oldest of them first.
                first = pend_count - n;
                for (int i = 0; i < n; i++) begin
                    predicted_acks.push_back('{KIND_TAKE_ENT, pend_cid[first + i],
                                               pend_port[first + i], TOTAL_W'(n), i + 1 == n});
                end
                pend_count = first;
            end
        end
    endfunction

    function automatic void add_row(logic cmd, logic [CID_W-1:0] cid, logic [PORT_W-1:0] port,
                                    logic [TOTAL_W-1:0] take, bit typed = 1'b0,
                                    t_ack_result want = '0);
        t_stim_row row;
        row.cmd = cmd;
        row.cid = cid;
        row.port = port;
        row.take = take;
        row.typed = typed;
        row.want = want;
        stim_rows.push_back(row);
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        mismatch_count++;
    endtask

    // Offers one item, with a random gap in front of it, and waits until it is
    // accepted. The valid stays high afterwards so back-to-back items need no
    // second assignment in the same step.
    task automatic send_item(logic cmd, logic [CID_W-1:0] cid, logic [PORT_W-1:0] port,
                             logic [TOTAL_W-1:0] take, bit typed = 1'b0,
                             t_ack_result want = '0);
        while ($urandom_range(0, 99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= {2'b00, take, port, cid};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        predict_ack_item(cmd, cid, port, take);
        if (typed) begin
            expected_acks.push_back(want);
        end else begin
            foreach (predicted_acks[i]) expected_acks.push_back(predicted_acks[i]);
        end
        if (cmd == CMD_ADD) begin
            adds_sent++;
        end else begin
            takes_sent++;
        end
    endtask

    // Receiver: random stalls, or a long hold-off when one is requested.
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end else if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Result checker: each accepted result is compared with the oldest expectation.
    always @(posedge i_clk) begin
        t_ack_result want;
        if (i_rst_n && o_m_tvalid && m_tready) begin
            if (expected_acks.size() == 0) begin
                report_mismatch("result with nothing pending", o_m_tdata[63:0], '0);
            end else begin
                want = expected_acks.pop_front();
                results_checked++;
                if (o_m_tuser !== want.kind)
                    report_mismatch("kind", 64'(o_m_tuser), 64'(want.kind));
                if (o_m_tdata[63:0] !== want.cid)
                    report_mismatch("ack_client_id", o_m_tdata[63:0], want.cid);
                if (o_m_tdata[79:64] !== want.port)
                    report_mismatch("ack_server_port", 64'(o_m_tdata[79:64]), 64'(want.port));
                if (o_m_tdata[85:80] !== want.total)
                    report_mismatch("ack_total", 64'(o_m_tdata[85:80]), 64'(want.total));
                if (o_m_tlast !== want.last)
                    report_mismatch("last", 64'(o_m_tlast), 64'(want.last));
            end
        end
    end

    // Watchdog: ends the run when neither side has moved an item for too long.
    always @(posedge i_clk) begin
        if ((s_tvalid && o_s_tready) || (o_m_tvalid && m_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL ack_coalescing_buffer_core");
            $finish;
        end
    end

    initial begin
        int phase_idle [4];
        int phase_stall [4];
        int sent;
        int pick;

        // Directed table: empty takes, field extremes, a full store, a flush,
        // clamped and partial takes.
        add_row(CMD_TAKE, '0, '0, 6'd0, 1'b1, EMPTY_MARKER);
        add_row(CMD_TAKE, '1, '1, 6'd63, 1'b1, EMPTY_MARKER);
        add_row(CMD_ADD, 64'h0, 16'h0000, 6'd0);
        add_row(CMD_ADD, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 6'd63);
        add_row(CMD_ADD, 64'hAAAA_AAAA_AAAA_AAAA, 16'h5555, 6'h2A);
        add_row(CMD_ADD, 64'h5555_5555_5555_5555, 16'hAAAA, 6'h15);
        add_row(CMD_ADD, 64'h8000_0000_0000_0001, 16'h8001, 6'd1);
        add_row(CMD_ADD, 64'h0123_4567_89AB_CDEF, 16'h1234, 6'd0);
        add_row(CMD_ADD, 64'hFEDC_BA98_7654_3210, 16'hABCD, 6'd0);
        add_row(CMD_ADD, 64'h7FFF_FFFF_FFFF_FFFE, 16'h7FFE, 6'd0);
        // A take of zero removes nothing even from a full store.
        add_row(CMD_TAKE, 64'h0, 16'h0, 6'd0, 1'b1, EMPTY_MARKER);
        add_row(CMD_ADD, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 6'd0);
        add_row(CMD_TAKE, 64'h0, 16'h0, 6'd5, 1'b1, EMPTY_MARKER);
        add_row(CMD_ADD, 64'h1, 16'h0001, 6'd0);
        add_row(CMD_ADD, 64'h2, 16'h0002, 6'd0);
        add_row(CMD_ADD, 64'h3, 16'h0003, 6'd0);
        add_row(CMD_TAKE, 64'h0, 16'h0, 6'd63);
        add_row(CMD_ADD, 64'h10, 16'h0010, 6'd0);
        add_row(CMD_ADD, 64'h11, 16'h0011, 6'd0);
        add_row(CMD_ADD, 64'h12, 16'h0012, 6'd0);
        add_row(CMD_ADD, 64'h13, 16'h0013, 6'd0);
        add_row(CMD_TAKE, 64'h0, 16'h0, 6'd1);
        add_row(CMD_TAKE, 64'h0, 16'h0, 6'd2);
        add_row(CMD_TAKE, 64'h0, 16'h0, 6'd1);
        add_row(CMD_TAKE, 64'h0, 16'h0, 6'd1, 1'b1, EMPTY_MARKER);

        phase_idle  = '{0, 59, 0, 11};
        phase_stall = '{0, 0, 59, 11};

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (stim_rows[i]) begin
            send_item(stim_rows[i].cmd, stim_rows[i].cid, stim_rows[i].port,
                      stim_rows[i].take, stim_rows[i].typed, stim_rows[i].want);
        end

        // Random part: runs of adds that reach a flush, single adds, and takes
        // of mostly small counts, across the four phases.
        for (int phase = 0; phase < 4; phase++) begin
            idle_pct = phase_idle[phase];
            stall_pct = phase_stall[phase];
            // Starve the output while the sender keeps offering items.
            if (phase == 0) hold_req++;
            sent = 0;
            while (sent < ITEMS_PER_PHASE) begin
                pick = $urandom_range(0, 99);
                if (pick < 25) begin
                    for (int k = 0; k <= ACK_SLOTS; k++) begin
                        send_item(CMD_ADD, {$urandom, $urandom}, 16'($urandom_range(0, 65535)),
                                  6'($urandom_range(0, 63)));
                        sent++;
                    end
                end else if (pick < 60) begin
                    send_item(CMD_ADD, {$urandom, $urandom}, 16'($urandom_range(0, 65535)),
                              6'($urandom_range(0, 63)));
                    sent++;
                end else begin
                    send_item(CMD_TAKE, {$urandom, $urandom}, 16'($urandom_range(0, 65535)),
                              ($urandom_range(0, 99) < 70) ? 6'($urandom_range(0, ACK_SLOTS + 1))
                                                           : 6'($urandom_range(0, 63)));
                    sent++;
                end
            end
        end

        s_tvalid <= 1'b0;
        idle_pct = 0;
        stall_pct = 0;
        while (expected_acks.size() != 0) @(posedge i_clk);
        repeat (ACK_SLOTS + 8) @(posedge i_clk);

        $display("Covered %0d adds and %0d takes, %0d flushes, %0d results checked.",
                 adds_sent, takes_sent, flushes_seen, results_checked);
        $display("Phases ran without idling, with sender gaps, receiver stalls and a long hold-off.");
        if (mismatch_count == 0) begin
            $display("PASS ack_coalescing_buffer_core");
        end else begin
            $display("FAIL ack_coalescing_buffer_core");
        end
        $finish;
    end

endmodule

[filelist.f]
design/acb_pkg.sv
design/acb_dpath.sv
design/acb_ctrl.sv
design/ack_coalescing_buffer_core.sv
test/ack_coalescing_buffer_core_tb.sv
